// ----- design/pcq_pkg.sv -----
`default_nettype none

package pcq_pkg;

  // Indexes of the configuration registers.
  typedef logic [1:0] pcq_cfg_idx_t;
  localparam pcq_cfg_idx_t CFG_FRAME_WIDTH  = 2'd0;
  localparam pcq_cfg_idx_t CFG_FRAME_HEIGHT = 2'd1;

  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [8:0] FRAME_WIDTH_RST  = 9'd80;
  localparam logic [7:0] FRAME_HEIGHT_RST = 8'd24;

  typedef struct packed {
    logic [7:0] column;
    logic [6:0] row;
    logic [7:0] color_index;
    logic       changed;
    logic       frame_end;
  } pcq_cmd_t;

endpackage

`default_nettype wire

// ----- design/pcq_pixel_if.sv -----
`default_nettype none

interface pcq_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- design/pcq_cmd_if.sv -----
`default_nettype none

interface pcq_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] column;
  logic [6:0] row;
  logic [7:0] color_index;
  logic       changed;
  logic       frame_end;

  modport source (output valid, output column, output row, output color_index,
                  output changed, output frame_end, input ready);
  modport sink   (input valid, input column, input row, input color_index,
                  input changed, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/pcq_cmd_fifo.sv -----
`default_nettype none

module pcq_cmd_fifo
  import pcq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire pcq_cmd_t push_data_i,
  input  wire logic     pop_i,
  output pcq_cmd_t      head_o,
  output logic          not_empty_o,
  output logic [1:0]    count_o
);

  localparam logic [1:0] LastSlot = 2'd2;

  pcq_cmd_t   slot_q [3];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign do_pop = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o      = slot_q[rd_ptr_q];
  assign not_empty_o = (count_q != 2'd0);
  assign count_o     = count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd3 && !pop_i) |-> !push_i)
    else $error("Command queue overflow.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("Command queue count lost a push.");

endmodule

`default_nettype wire

// ----- design/pixel_cube_quantize_frame_diff.sv -----
// Result path: stage-two registers, then the result queue; only changed or frame-end
// pixels give a result. Throughput: one pixel per cycle while the queue has room and no
// clearing pass runs, set by the frame store's single read and single write port used
// as one read-modify-write per pixel. Reset: asynchronous, active low; afterwards a
// clearing pass zeroes all MAX_COLUMNS*MAX_ROWS store entries (32768 by default), one
// per cycle, while pixels are held off. Configuration writes are taken throughout.
`default_nettype none

module pixel_cube_quantize_frame_diff
  import pcq_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  pcq_pixel_if.sink                  pix_i,
  pcq_cmd_if.source                  cmd_o,
  input  wire logic                  cfg_we_i,
  input  wire pcq_cfg_idx_t          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WCW   = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int unsigned WRW   = (RW + 1 > 8) ? RW + 1 : 8;

  localparam logic [WCW-1:0] MaxColsW = WCW'(MAX_COLUMNS);
  localparam logic [WRW-1:0] MaxRowsW = WRW'(MAX_ROWS);
  localparam logic [AW-1:0]  MaxColsA = AW'(MAX_COLUMNS);
  localparam logic [AW-1:0]  LastAddr = AW'(Depth - 1);

  function automatic logic [2:0] level_of(input logic [7:0] c);
    logic [10:0] prod;
    prod = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
    return prod[10:8];
  endfunction

  // Configuration.
  logic [8:0] frame_width_q;
  logic [7:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [WCW-1:0] width_ext, width_eff;
  logic [WRW-1:0] height_ext, height_eff;

  always_comb begin
    width_ext  = WCW'(frame_width_q);
    height_ext = WRW'(frame_height_q);
    if (width_ext == '0) begin
      width_eff = WCW'(1);
    end else if (width_ext > MaxColsW) begin
      width_eff = MaxColsW;
    end else begin
      width_eff = width_ext;
    end
    if (height_ext == '0) begin
      height_eff = WRW'(1);
    end else if (height_ext > MaxRowsW) begin
      height_eff = MaxRowsW;
    end else begin
      height_eff = height_ext;
    end
  end

  // Clearing pass after reset.
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Stage one: accept, position, quantize and read the store.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          pix_fire;
  logic          last_col, last_row;
  logic [7:0]    color;
  logic [AW-1:0] rd_addr;
  logic [1:0]    fifo_count;
  logic          s1_valid_q;

  assign pix_i.ready = !clr_q && ({1'b0, fifo_count} + {2'b00, s1_valid_q} <= 3'd2);
  assign pix_fire    = pix_i.valid && pix_i.ready;

  assign last_col = (WCW'(col_q) + WCW'(1)) >= width_eff;
  assign last_row = (WRW'(row_q) + WRW'(1)) >= height_eff;

  assign color = 8'd16 + 8'd36 * {5'd0, level_of(pix_i.red)}
               + 8'd6 * {5'd0, level_of(pix_i.green)} + {5'd0, level_of(pix_i.blue)};

  assign rd_addr = AW'(AW'(row_q) * MaxColsA + AW'(col_q));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage two registers.
  logic [AW-1:0] s1_addr_q;
  logic [7:0]    s1_color_q;
  logic [7:0]    s1_col_q;
  logic [6:0]    s1_row_q;
  logic          s1_fend_q;
  logic          s1_fwd_q;
  logic [7:0]    s1_fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      s1_addr_q     <= rd_addr;
      s1_color_q    <= color;
      s1_col_q      <= 8'(col_q);
      s1_row_q      <= 7'(row_q);
      s1_fend_q     <= last_col && last_row;
      s1_fwd_q      <= s1_valid_q && (rd_addr == s1_addr_q);
      s1_fwd_data_q <= s1_color_q;
    end
  end

  // Frame store.
  logic [7:0]    frame_store_q [Depth];
  logic [7:0]    rd_data_q;
  logic [7:0]    old_color;
  logic          changed;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;

  assign old_color = s1_fwd_q ? s1_fwd_data_q : rd_data_q;
  assign changed   = (old_color != s1_color_q);
  assign st_we     = clr_q || (s1_valid_q && changed);
  assign st_waddr  = clr_q ? clr_addr_q : s1_addr_q;
  assign st_wdata  = clr_q ? 8'd0 : s1_color_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      frame_store_q[st_waddr] <= st_wdata;
    end
    rd_data_q <= frame_store_q[rd_addr];
  end

  // Result queue.
  logic     push;
  pcq_cmd_t push_data;
  pcq_cmd_t head;
  logic     head_valid;

  assign push = s1_valid_q && (changed || s1_fend_q);

  always_comb begin
    push_data.column      = s1_col_q;
    push_data.row         = s1_row_q;
    push_data.color_index = s1_color_q;
    push_data.changed     = changed;
    push_data.frame_end   = s1_fend_q;
  end

  pcq_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (cmd_o.ready),
    .head_o      (head),
    .not_empty_o (head_valid),
    .count_o     (fifo_count)
  );

  assign cmd_o.valid       = head_valid;
  assign cmd_o.column      = head.column;
  assign cmd_o.row         = head.row;
  assign cmd_o.color_index = head.color_index;
  assign cmd_o.changed     = head.changed;
  assign cmd_o.frame_end   = head.frame_end;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_valid_q)
    else $error("Pixel in flight during the clearing pass.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fend_q) |-> push)
    else $error("Frame end pixel produced no command.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_color_q >= 8'd16 && s1_color_q <= 8'd231))
    else $error("Colour index outside the cube.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_fire && s1_valid_q && s1_fend_q) |-> (rd_addr != s1_addr_q || s1_addr_q == '0))
    else $error("Consecutive pixels share a store entry away from a one-pixel frame.");

endmodule

`default_nettype wire
